@@ hdl/rcs_pkg.sv @@
// Shared types and constants for the RC steering command shaper.
package rcs_pkg;

  localparam int unsigned CH_W   = 11;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned HALF_W = 16;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned PROD_W = CH_W + DATA_W;
  localparam int unsigned FRAC_DROP = 8;

  // Register indexes on the configuration port
  localparam logic [IDX_W-1:0] REG_DB_LOW   = 3'd0;
  localparam logic [IDX_W-1:0] REG_DB_HIGH  = 3'd1;
  localparam logic [IDX_W-1:0] REG_GAIN_BLW = 3'd2;
  localparam logic [IDX_W-1:0] REG_GAIN_ABV = 3'd3;
  localparam logic [IDX_W-1:0] REG_HOLD_MS  = 3'd4;
  localparam logic [IDX_W-1:0] REG_DECAY    = 3'd5;
  localparam logic [IDX_W-1:0] REG_ZERO     = 3'd6;

  localparam logic [CH_W-1:0]   RST_DB_LOW  = 11'd1200;
  localparam logic [CH_W-1:0]   RST_DB_HIGH = 11'd1260;
  localparam logic [HALF_W-1:0] RST_HOLD_MS = 16'd300;
  localparam logic [HALF_W-1:0] RST_DECAY   = 16'd328;

  localparam logic [DATA_W-1:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] NEG_MAG = 32'h8000_0000;

  typedef struct packed {
    logic [CH_W-1:0]   db_low;
    logic [CH_W-1:0]   db_high;
    logic [DATA_W-1:0] gain_below;
    logic [DATA_W-1:0] gain_above;
    logic [HALF_W-1:0] hold_ms;
    logic [HALF_W-1:0] decay_step;
    logic [DATA_W-1:0] zero_offset;
  } rcs_cfg_t;

  // One classified sample on its way to the back end
  typedef struct packed {
    logic              active;
    logic              below;
    logic [DATA_W-1:0] mag;
    logic [DATA_W-1:0] now_ms;
  } rcs_item_t;

endpackage

@@ hdl/rcs_front.sv @@
// Front end: deadband classification and scaled offset magnitude.
module rcs_front (
  input  logic [rcs_pkg::CH_W-1:0]   in_steer_channel,
  input  logic [rcs_pkg::DATA_W-1:0] in_now_ms,
  input  rcs_pkg::rcs_cfg_t          cfg,
  output rcs_pkg::rcs_item_t         item
);
  import rcs_pkg::*;

  logic              below;
  logic              above;
  logic [CH_W-1:0]   delta;
  logic [DATA_W-1:0] gain;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-FRAC_DROP-1:0] scaled;
  logic [DATA_W-1:0] limit;

  always_comb begin
    below  = in_steer_channel < cfg.db_low;
    above  = in_steer_channel > cfg.db_high;
    // below wins when the edges are crossed
    delta  = below ? (cfg.db_low - in_steer_channel) : (in_steer_channel - cfg.db_high);
    gain   = below ? cfg.gain_below : cfg.gain_above;
    prod   = {{DATA_W{1'b0}}, delta} * {{CH_W{1'b0}}, gain};
    scaled = prod[PROD_W-1:FRAC_DROP];
    limit  = below ? NEG_MAG : POS_MAX;

    item.active = below | above;
    item.below  = below;
    item.now_ms = in_now_ms;
    if (scaled > {{(PROD_W-FRAC_DROP-DATA_W){1'b0}}, limit}) begin
      item.mag = limit;
    end else begin
      item.mag = scaled[DATA_W-1:0];
    end
  end

endmodule

@@ hdl/rcs_fifo.sv @@
// Two-entry queue between the front and back ends.
module rcs_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rcs_pkg::rcs_item_t push_item,
  input  logic               pop,
  output logic               full,
  output logic               nonempty,
  output rcs_pkg::rcs_item_t head
);
  import rcs_pkg::*;

  rcs_item_t  mem_r [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full     = cnt_r == 2'd2;
  assign nonempty = cnt_r != 2'd0;
  assign head     = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push ? ~wr_r : wr_r;
    rd_nxt  = pop ? ~rd_r : rd_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_item;
    end
  end

endmodule

@@ hdl/rcs_back.sv @@
// Back end: held offset update, hold/decay, output sum and result register.
module rcs_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rcs_pkg::rcs_cfg_t           cfg,
  input  logic                        item_valid,
  input  rcs_pkg::rcs_item_t          item,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [rcs_pkg::DATA_W-1:0] out_target_position,
  output logic                        out_stick_active
);
  import rcs_pkg::*;

  logic [DATA_W-1:0] held_r, held_nxt;
  logic [DATA_W-1:0] last_r, last_nxt;
  logic              out_valid_r;
  logic [DATA_W-1:0] target_r, target_nxt;
  logic              active_r;

  logic [DATA_W-1:0] age;
  logic [DATA_W:0]   step33;
  logic [DATA_W:0]   dec33;
  logic [DATA_W:0]   inc33;
  logic [DATA_W:0]   sum33;

  assign pop                 = item_valid & (~out_valid_r | out_ready);
  assign out_valid           = out_valid_r;
  assign out_target_position = target_r;
  assign out_stick_active    = active_r;

  always_comb begin
    age      = item.now_ms - last_r;
    step33   = {{(DATA_W+1-HALF_W){1'b0}}, cfg.decay_step};
    dec33    = {held_r[DATA_W-1], held_r} - step33;
    inc33    = {held_r[DATA_W-1], held_r} + step33;
    held_nxt = held_r;
    last_nxt = last_r;
    if (item.active) begin
      held_nxt = item.below ? (~item.mag + 1'b1) : item.mag;
      last_nxt = item.now_ms;
    end else if (age > {{(DATA_W-HALF_W){1'b0}}, cfg.hold_ms}) begin
      if (held_r[DATA_W-1]) begin
        // negative: step up, stop at zero
        held_nxt = inc33[DATA_W] ? inc33[DATA_W-1:0] : '0;
      end else if (held_r != '0) begin
        held_nxt = (dec33[DATA_W] || dec33 == '0) ? '0 : dec33[DATA_W-1:0];
      end
    end

    sum33 = {cfg.zero_offset[DATA_W-1], cfg.zero_offset} + {held_nxt[DATA_W-1], held_nxt};
    if (sum33[DATA_W] != sum33[DATA_W-1]) begin
      target_nxt = sum33[DATA_W] ? NEG_MAG : POS_MAX;
    end else begin
      target_nxt = sum33[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        held_r <= held_nxt;
        last_r <= last_nxt;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      target_r <= target_nxt;
      active_r <= item.active;
    end
  end

endmodule

@@ hdl/rc_steering_command_shaper_unit.sv @@
// RC steering command shaper top level: register file, front, queue, back.
// Takes one steering sample per clock while in_ready is high and returns one target
// position per sample, in order. A result passes the queue and result registers:
// the front end's deadband test and 11x32 multiply settle ahead of the queue
// register, and the back end's held-offset update and output sum settle ahead of
// the result register, so while out_ready stays high the rate is one sample per
// cycle. in_ready falls only while the two-entry queue between them is full, which
// happens only while out_ready holds a result back. Registers sit at byte addresses
// 4*i (deadband_low, deadband_high, gain_below, gain_above, hold_ms, decay_step,
// zero_offset); write them only with no sample in flight, unchecked by the block.
module rc_steering_command_shaper_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rcs_pkg::CH_W-1:0]          in_steer_channel,
  input  logic [rcs_pkg::DATA_W-1:0]        in_now_ms,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [rcs_pkg::DATA_W-1:0] out_target_position,
  output logic                              out_stick_active,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [rcs_pkg::ADDR_W-1:0]        cfg_paddr,
  input  logic [rcs_pkg::DATA_W-1:0]        cfg_pwdata,
  output logic [rcs_pkg::DATA_W-1:0]        cfg_prdata,
  output logic                              cfg_pready
);
  import rcs_pkg::*;

  rcs_cfg_t         cfg_r, cfg_nxt;
  logic             cfg_wr;
  logic [IDX_W-1:0] cfg_idx;
  rcs_item_t        front_item;
  rcs_item_t        head;
  logic             q_full;
  logic             q_nonempty;
  logic             q_pop;
  logic             q_push;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[ADDR_W-1:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (cfg_idx)
        REG_DB_LOW:   cfg_nxt.db_low      = cfg_pwdata[CH_W-1:0];
        REG_DB_HIGH:  cfg_nxt.db_high     = cfg_pwdata[CH_W-1:0];
        REG_GAIN_BLW: cfg_nxt.gain_below  = cfg_pwdata;
        REG_GAIN_ABV: cfg_nxt.gain_above  = cfg_pwdata;
        REG_HOLD_MS:  cfg_nxt.hold_ms     = cfg_pwdata[HALF_W-1:0];
        REG_DECAY:    cfg_nxt.decay_step  = cfg_pwdata[HALF_W-1:0];
        REG_ZERO:     cfg_nxt.zero_offset = cfg_pwdata;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_DB_LOW:   cfg_prdata = {{(DATA_W-CH_W){1'b0}}, cfg_r.db_low};
      REG_DB_HIGH:  cfg_prdata = {{(DATA_W-CH_W){1'b0}}, cfg_r.db_high};
      REG_GAIN_BLW: cfg_prdata = cfg_r.gain_below;
      REG_GAIN_ABV: cfg_prdata = cfg_r.gain_above;
      REG_HOLD_MS:  cfg_prdata = {{(DATA_W-HALF_W){1'b0}}, cfg_r.hold_ms};
      REG_DECAY:    cfg_prdata = {{(DATA_W-HALF_W){1'b0}}, cfg_r.decay_step};
      REG_ZERO:     cfg_prdata = cfg_r.zero_offset;
      default:      cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.db_low      <= RST_DB_LOW;
      cfg_r.db_high     <= RST_DB_HIGH;
      cfg_r.gain_below  <= '0;
      cfg_r.gain_above  <= '0;
      cfg_r.hold_ms     <= RST_HOLD_MS;
      cfg_r.decay_step  <= RST_DECAY;
      cfg_r.zero_offset <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_ready = ~q_full;
  assign q_push   = in_valid & ~q_full;

  rcs_front u_front (
    .in_steer_channel (in_steer_channel),
    .in_now_ms        (in_now_ms),
    .cfg              (cfg_r),
    .item             (front_item)
  );

  rcs_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (front_item),
    .pop       (q_pop),
    .full      (q_full),
    .nonempty  (q_nonempty),
    .head      (head)
  );

  rcs_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .item_valid          (q_nonempty),
    .item                (head),
    .pop                 (q_pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_target_position (out_target_position),
    .out_stick_active    (out_stick_active)
  );

endmodule

@@ hdl/rcs_checker.sv @@
// Port-level checks for the steering shaper, bound to the top level.
module rcs_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [rcs_pkg::DATA_W-1:0] out_target_position,
  input logic                              out_stick_active,
  input logic                              cfg_psel,
  input logic                              cfg_pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_target_position)
      && $stable(out_stick_active))
    else $error("result dropped or changed while stalled");

  // an accepted request shows on the output after the queue and result registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> ##1 out_valid)
    else $error("no result two cycles after a request");

  // queue fills only behind a stalled result
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel |-> cfg_pready)
    else $error("config port wait state");

endmodule

bind rc_steering_command_shaper_unit rcs_checker u_rcs_checker (.*);
